[rtl/core/mcwa_pkg.sv]
`timescale 1ns / 1ps

package mcwa_pkg;

  // Table geometry
  localparam int MAX_CLIENTS = 16;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int TIME_W      = 64;
  localparam int TMO_W       = 32;
  localparam int ENTRY_W     = KEY_W + TIME_W;
  localparam int IDX_W       = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);

  // Only the low KEY_BYTES bytes of a key take part
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  localparam logic [TMO_W-1:0] TIMEOUT_RST = 32'd1000000;

  // Operation codes
  localparam logic [1:0] OP_REG   = 2'd0;
  localparam logic [1:0] OP_FEED  = 2'd1;
  localparam logic [1:0] OP_KICK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_ALREADY = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_FROZEN  = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;
  localparam logic [2:0] ST_STALE   = 3'd6;
  localparam logic [2:0] ST_GATED   = 3'd7;

  // Per-entry check result
  typedef struct packed {
    logic match;
    logic stale;
  } chk_t;

endpackage

[rtl/core/mcwa_ram.sv]
`timescale 1ns / 1ps

// Generic single write / single read RAM, registered read
module mcwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/mcwa_entry_check.sv]
`timescale 1ns / 1ps

// Compares one table entry against the current key and kick time
module mcwa_entry_check
  import mcwa_pkg::*;
(
  input  logic [ENTRY_W-1:0] entry,
  input  logic               fed,
  input  logic [KEY_W-1:0]   key,
  input  logic [TIME_W-1:0]  now,
  input  logic [TMO_W-1:0]   limit,
  output chk_t               chk
);

  logic [KEY_W-1:0]  ent_key;
  logic [TIME_W-1:0] ent_time;
  logic [TIME_W-1:0] elapsed;

  assign ent_key  = entry[ENTRY_W-1:TIME_W];
  assign ent_time = entry[TIME_W-1:0];

  // wrapping elapsed time since the last feed
  assign elapsed   = now - ent_time;
  assign chk.match = (ent_key == key);
  assign chk.stale = !fed || (elapsed > {{(TIME_W-TMO_W){1'b0}}, limit});

endmodule

[rtl/core/multi_client_watchdog_aggregator.sv]
`timescale 1ns / 1ps

// Multi-client watchdog aggregator.
// Command channel: an item (in_operation, in_module_key, in_now_us,
// in_gate_ok) transfers on a clock edge with start high and busy low.
// Each item gives exactly one result: out_status and out_hw_kick are shown
// for one cycle with out_valid high; the receiver cannot stall, so every
// strobed result must be captured in that cycle.
// Items settled from the command alone (invalid key, frozen registration,
// gated kick, clear) strobe the result the cycle after the transfer. Other
// register, feed and kick items scan the client table in its RAM, one entry
// read per cycle; busy stays high through the scan and the write-back state,
// and the result strobes in the first cycle with busy low. The scan reads
// one entry at a time because the table RAM has a single read port.
// Configuration: cfg_we writes cfg_wdata to the timeout register; write it
// only while the block is idle. A timeout of 0 acts as 1.
// Reset (rst_n low, synchronous) empties the table, unfreezes the registry,
// and loads the timeout with 1000000 us. No clearing pass is needed: the
// RAM is only read below the client count.
module multi_client_watchdog_aggregator
  import mcwa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_operation,
  input  logic [KEY_W-1:0]  in_module_key,
  input  logic [TIME_W-1:0] in_now_us,
  input  logic              in_gate_ok,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic              out_hw_kick,
  input  logic              cfg_we,
  input  logic [TMO_W-1:0]  cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // control state
  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic                   chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   hit_r, hit_nxt;
  logic [IDX_W-1:0]       hit_idx_r, hit_idx_nxt;
  logic                   stale_r, stale_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   frozen_r, frozen_nxt;
  logic [MAX_CLIENTS-1:0] fed_r, fed_nxt;
  logic [TMO_W-1:0]       timeout_r, timeout_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // payload
  logic [1:0]             op_r, op_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [2:0]             out_status_r, out_status_nxt;
  logic                   out_hw_kick_r, out_hw_kick_nxt;

  // RAM port
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;

  logic                   accept;
  logic [KEY_W-1:0]       in_key;
  logic [TMO_W-1:0]       limit;
  logic                   issue;
  chk_t                   chk;

  assign accept    = start && !busy;
  assign in_key    = in_module_key & KEY_MASK;
  assign limit     = (timeout_r == '0) ? {{(TMO_W-1){1'b0}}, 1'b1} : timeout_r;
  assign issue     = (state_r == S_SCAN) && (scan_idx_r < count_r);
  assign ram_raddr = scan_idx_r[IDX_W-1:0];

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_hw_kick = out_hw_kick_r;

  mcwa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CLIENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mcwa_entry_check u_check (
    .entry (ram_rdata),
    .fed   (fed_r[chk_idx_r]),
    .key   (key_r),
    .now   (now_r),
    .limit (limit),
    .chk   (chk)
  );

  // sequencer: decode, table scan, write-back
  always_comb begin
    state_nxt       = state_r;
    scan_idx_nxt    = scan_idx_r;
    chk_v_nxt       = 1'b0;
    chk_idx_nxt     = chk_idx_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    stale_nxt       = stale_r;
    count_nxt       = count_r;
    frozen_nxt      = frozen_r;
    fed_nxt         = fed_r;
    timeout_nxt     = cfg_we ? cfg_wdata : timeout_r;
    out_valid_nxt   = 1'b0;
    op_nxt          = op_r;
    key_nxt         = key_r;
    now_nxt         = now_r;
    out_status_nxt  = out_status_r;
    out_hw_kick_nxt = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = hit_idx_r;
    ram_wdata       = {key_r, now_r};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt       = in_operation;
          key_nxt      = in_key;
          now_nxt      = in_now_us;
          scan_idx_nxt = '0;
          hit_nxt      = 1'b0;
          hit_idx_nxt  = '0;
          stale_nxt    = 1'b0;
          unique case (in_operation)
            OP_REG: begin
              if (in_key == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_INVALID;
              end else if (frozen_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FROZEN;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_FEED: begin
              if (in_key == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_INVALID;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_KICK: begin
              frozen_nxt = 1'b1;
              if (!in_gate_ok) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_GATED;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR: begin
              count_nxt      = '0;
              frozen_nxt     = 1'b0;
              fed_nxt        = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // one read issued per cycle; the registered read data is checked by u_check
        if (issue) begin
          chk_v_nxt    = 1'b1;
          chk_idx_nxt  = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (chk_v_r) begin
          if (chk.match && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = chk_idx_r;
          end
          if (chk.stale) begin
            stale_nxt = 1'b1;
          end
        end
        if (!issue) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        unique case (op_r)
          OP_REG: begin
            if (hit_r) begin
              out_status_nxt = ST_ALREADY;
            end else if (count_r >= CNT_W'(MAX_CLIENTS)) begin
              out_status_nxt = ST_FULL;
            end else begin
              ram_we                        = 1'b1;
              ram_waddr                     = count_r[IDX_W-1:0];
              ram_wdata                     = {key_r, {TIME_W{1'b0}}};
              fed_nxt[count_r[IDX_W-1:0]]   = 1'b0;
              count_nxt                     = count_r + 1'b1;
              out_status_nxt                = ST_OK;
            end
          end
          OP_FEED: begin
            if (hit_r) begin
              ram_we             = 1'b1;
              fed_nxt[hit_idx_r] = 1'b1;
              out_status_nxt     = ST_OK;
            end else begin
              out_status_nxt = ST_UNKNOWN;
            end
          end
          OP_KICK: begin
            if (stale_r) begin
              out_status_nxt = ST_STALE;
            end else begin
              fed_nxt         = '0;
              out_status_nxt  = ST_OK;
              out_hw_kick_nxt = 1'b1;
            end
          end
          default: begin
            out_status_nxt = ST_OK;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      scan_idx_r    <= '0;
      chk_v_r       <= 1'b0;
      chk_idx_r     <= '0;
      hit_r         <= 1'b0;
      hit_idx_r     <= '0;
      stale_r       <= 1'b0;
      count_r       <= '0;
      frozen_r      <= 1'b0;
      fed_r         <= '0;
      timeout_r     <= TIMEOUT_RST;
      out_valid_r   <= 1'b0;
      out_hw_kick_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      scan_idx_r    <= scan_idx_nxt;
      chk_v_r       <= chk_v_nxt;
      chk_idx_r     <= chk_idx_nxt;
      hit_r         <= hit_nxt;
      hit_idx_r     <= hit_idx_nxt;
      stale_r       <= stale_nxt;
      count_r       <= count_nxt;
      frozen_r      <= frozen_nxt;
      fed_r         <= fed_nxt;
      timeout_r     <= timeout_nxt;
      out_valid_r   <= out_valid_nxt;
      out_hw_kick_r <= out_hw_kick_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    now_r        <= now_nxt;
    out_status_r <= out_status_nxt;
  end

  // checks
  a_kick_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_hw_kick |-> out_valid && (out_status == ST_OK))
    else $error("hw kick without ok result");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CLIENTS))
    else $error("client count beyond table size");

  a_kick_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_operation == OP_KICK) |=> frozen_r)
    else $error("kick request did not freeze registry");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_DONE))
    else $error("table write outside write-back");

  // a result comes either from a transfer or from a finished scan
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept) || $past(state_r == S_DONE))
    else $error("result without a transfer or a finished scan");

endmodule
